// ===== rtl/pfba_pkg.sv =====
package pfba_pkg;

    // default geometry
    localparam int BITMAP_WORDS_DEF = 32;
    localparam int PAGE_SHIFT_DEF   = 21;

    // fixed field widths
    localparam int ADDR_W      = 48;
    localparam int OP_W        = 3;
    localparam int FRAME_IN_W  = 12;
    localparam int FRAME_OUT_W = 11;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 12;
    localparam int WORD_W      = 64;
    localparam int BIT_W       = 6;

    // fixed device window, byte addresses
    localparam logic [63:0] DEV_LOW  = 64'h0000_0000_fec0_0000;
    localparam logic [63:0] DEV_HIGH = 64'h0000_0000_ffff_ffff;

    typedef enum logic [OP_W-1:0] {
        OP_INIT,
        OP_ADD,
        OP_ALLOC,
        OP_FREE_ADDR,
        OP_FREE_FRAME
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_OOM,
        ST_RANGE
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_A_FIRST,
        S_A_STOP,
        S_A_KLO,
        S_A_KHI,
        S_A_RANGE,
        S_A_RD,
        S_A_LD,
        S_A_BIT,
        S_A_WR,
        S_L_SCAN,
        S_L_BIT,
        S_L_SET,
        S_F_SHIFT,
        S_F_CHK,
        S_F_MOD,
        S_DONE
    } t_state;

endpackage

// ===== rtl/pfba_bitmap_ram.sv =====
module pfba_bitmap_ram
    import pfba_pkg::*;
#(
    parameter int WORDS = BITMAP_WORDS_DEF,
    parameter int AW    = (WORDS > 1) ? $clog2(WORDS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clr,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [WORD_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [WORDS];
    logic [WORDS-1:0]  r_valid;
    logic [WORD_W-1:0] r_q;
    logic              r_qv;

    // a word never written since reset or init reads as all used
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_clr) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q  <= r_mem[i_raddr];
        r_qv <= r_valid[i_raddr];
    end

    assign o_rdata = r_qv ? r_q : '1;

endmodule

// ===== rtl/pfba_shift_unit.sv =====
module pfba_shift_unit
    import pfba_pkg::*;
#(
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF,
    parameter int QW         = ADDR_W + 1 - PAGE_SHIFT
) (
    input  logic [ADDR_W-1:0] i_a,
    input  logic [ADDR_W-1:0] i_b,
    input  logic              i_round,
    output logic [QW-1:0]     o_q
);

    localparam logic [ADDR_W-1:0] PAGE_M1 = ADDR_W'((64'd1 << PAGE_SHIFT) - 64'd1);

    logic [ADDR_W:0] w_sum;

    // (a + b) >> shift, or ceil(a / page) when rounding
    assign w_sum = {1'b0, i_a} + {1'b0, (i_round ? PAGE_M1 : i_b)};
    assign o_q   = w_sum[ADDR_W:PAGE_SHIFT];

endmodule

// ===== rtl/page_frame_bitmap_allocator.sv =====
// Page frame bitmap allocator: one bit per physical page frame (1 = used),
// BITMAP_WORDS words of 64 frames, pages of 2^PAGE_SHIFT bytes. A command
// is taken when start is high and busy is low; busy stays high until the
// result beat, which is shown for exactly one cycle with o_valid high and
// cannot be held off, so sample it when it comes. busy is already low in
// that cycle and a new command may be issued there. After reset every
// frame reads as used (per-word valid bits, no clearing pass), and the
// kernel window registers are zero. The steps of each command follow from
// the bitmap RAM's single registered read port and the shared shift/add unit:
//   init and unused op codes: straight to done.
//   free by frame: range check, then read and modify (out of range goes
//   straight to done); free by address first takes a shift step.
//   allocate: the word scan reads one word per cycle, then a six-step
//   binary search finds the lowest free bit and the word is written back
//   with it set; out of memory goes to done after the last word.
//   add region: setup, in which the shared unit works out first page, end
//   page and the kernel window in page units, then the range check; then
//   per bitmap word touched a read, a load, a bit step for each page
//   walked and a write back, then the done state and the result beat.
// Pages skipped for the kernel or device window still take their bit step.
module page_frame_bitmap_allocator
    import pfba_pkg::*;
#(
    parameter int BITMAP_WORDS = BITMAP_WORDS_DEF,
    parameter int PAGE_SHIFT   = PAGE_SHIFT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // command
    input  logic                   start,
    output logic                   busy,
    input  logic [OP_W-1:0]        i_op,
    input  logic [ADDR_W-1:0]      i_addr,
    input  logic [ADDR_W-1:0]      i_length,
    input  logic [FRAME_IN_W-1:0]  i_frame_in,
    // result
    output logic                   o_valid,
    output logic [FRAME_OUT_W-1:0] o_frame,
    output logic [STATUS_W-1:0]    o_status,
    output logic [COUNT_W-1:0]     o_pages_freed,
    output logic [COUNT_W-1:0]     o_usable_total,
    // register port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [3:0]             paddr,
    input  logic [63:0]            pwdata,
    output logic [63:0]            prdata,
    output logic                   pready
);

    localparam int FRAME_COUNT = BITMAP_WORDS * 64;
    localparam int WW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int CW = $clog2(FRAME_COUNT + 1);          // holds the frame count itself
    localparam int QW = ADDR_W + 1 - PAGE_SHIFT;          // page number of a byte address
    localparam int XW = ((QW > CW) ? QW : CW) + 1;        // common compare width
    localparam int COUNT_MAX_I = (FRAME_COUNT < 4095) ? FRAME_COUNT : 4095;

    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(COUNT_MAX_I);
    localparam logic [XW-1:0]      FC_X      = XW'(FRAME_COUNT);
    localparam logic [WW-1:0]      LAST_W    = WW'(BITMAP_WORDS - 1);
    localparam logic [63:0]        PAGE_M1   = (64'd1 << PAGE_SHIFT) - 64'd1;
    // device window in page units: skip f when f+1 >= DEV_KLO and f < DEV_KHI
    localparam logic [XW-1:0] DEV_KLO = XW'((DEV_LOW + PAGE_M1) >> PAGE_SHIFT);
    localparam logic [XW-1:0] DEV_KHI = XW'((DEV_HIGH + PAGE_M1) >> PAGE_SHIFT);

    localparam logic REG_KSTART = 1'b0;
    localparam logic REG_KEND   = 1'b1;

    // ---------------------------------------------------------------
    // Register port: kernel_start at 0x0, kernel_end at 0x8
    // ---------------------------------------------------------------
    logic [ADDR_W-1:0] r_kstart;
    logic [ADDR_W-1:0] r_kend;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kstart <= '0;
            r_kend   <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3])
                REG_KSTART: r_kstart <= pwdata[ADDR_W-1:0];
                REG_KEND:   r_kend   <= pwdata[ADDR_W-1:0];
                default:    r_kstart <= r_kstart;
            endcase
        end
    end

    always_comb begin
        case (paddr[3])
            REG_KSTART: prdata = {{(64-ADDR_W){1'b0}}, r_kstart};
            REG_KEND:   prdata = {{(64-ADDR_W){1'b0}}, r_kend};
            default:    prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer state
    // ---------------------------------------------------------------
    t_state              r_state, n_state;
    logic [OP_W-1:0]     r_op, n_op;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [ADDR_W-1:0]   r_len, n_len;
    logic [XW-1:0]       r_lo, n_lo;       // first page, or frame to free
    logic [XW-1:0]       r_hi, n_hi;       // end page (exclusive)
    logic [XW-1:0]       r_klo, n_klo;     // kernel window, page units
    logic [XW-1:0]       r_khi, n_khi;
    logic [CW-1:0]       r_f, n_f;         // page walker
    logic [WW-1:0]       r_widx, n_widx;
    logic [WORD_W-1:0]   r_word, n_word;
    logic [WORD_W-1:0]   r_sh, n_sh;       // search window
    logic [BIT_W-1:0]    r_bit, n_bit;
    logic [2:0]          r_k, n_k;
    logic [WW-1:0]       r_w, n_w;         // scan read pointer
    logic                r_pend, n_pend;   // scan read in flight
    logic [WW-1:0]       r_pidx, n_pidx;
    logic [COUNT_W-1:0]  r_n, n_n;
    logic [COUNT_W-1:0]  r_usable, n_usable;
    t_status             r_stat, n_stat;
    logic [FRAME_OUT_W-1:0] r_fr, n_fr;

    logic                   r_ovalid, n_ovalid;
    logic [FRAME_OUT_W-1:0] r_oframe, n_oframe;
    logic [STATUS_W-1:0]    r_ostatus, n_ostatus;
    logic [COUNT_W-1:0]     r_ofreed, n_ofreed;
    logic [COUNT_W-1:0]     r_ototal, n_ototal;

    // shared shift/add unit
    logic [ADDR_W-1:0] su_a, su_b;
    logic              su_round;
    logic [QW-1:0]     su_q;

    pfba_shift_unit #(
        .PAGE_SHIFT (PAGE_SHIFT),
        .QW         (QW)
    ) u_shift (
        .i_a     (su_a),
        .i_b     (su_b),
        .i_round (su_round),
        .o_q     (su_q)
    );

    // bitmap
    logic              ram_clr, ram_we;
    logic [WW-1:0]     ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;

    pfba_bitmap_ram #(
        .WORDS (BITMAP_WORDS),
        .AW    (WW)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (ram_clr),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // Datapath helpers
    // ---------------------------------------------------------------
    logic [XW-1:0]      f_x, f1_x, stop_c;
    logic               skip;
    logic [CW-1:0]      f_next;
    logic [6:0]         h;
    logic [WORD_W-1:0]  h_mask;
    logic               low_ones;
    logic [COUNT_W:0]   tot_sum;

    assign f_x    = XW'(r_f);
    assign f1_x   = f_x + XW'(1);
    assign f_next = r_f + CW'(1);
    // page touches a window when its top reaches the window start and it
    // begins below the window end
    assign skip   = ((f1_x >= r_klo) && (f_x < r_khi)) ||
                    ((f1_x >= DEV_KLO) && (f_x < DEV_KHI));
    assign stop_c = (r_hi > FC_X) ? FC_X : r_hi;

    assign h        = 7'd32 >> r_k;
    assign h_mask   = (64'h1 << h) - 64'h1;
    assign low_ones = (r_sh & h_mask) == h_mask;

    assign tot_sum  = {1'b0, r_usable} + {1'b0, r_n};

    // ---------------------------------------------------------------
    // Next state and outputs
    // ---------------------------------------------------------------
    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_addr    = r_addr;
        n_len     = r_len;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_klo     = r_klo;
        n_khi     = r_khi;
        n_f       = r_f;
        n_widx    = r_widx;
        n_word    = r_word;
        n_sh      = r_sh;
        n_bit     = r_bit;
        n_k       = r_k;
        n_w       = r_w;
        n_pend    = r_pend;
        n_pidx    = r_pidx;
        n_n       = r_n;
        n_usable  = r_usable;
        n_stat    = r_stat;
        n_fr      = r_fr;
        n_ovalid  = 1'b0;
        n_oframe  = r_oframe;
        n_ostatus = r_ostatus;
        n_ofreed  = r_ofreed;
        n_ototal  = r_ototal;

        su_a      = r_addr;
        su_b      = '0;
        su_round  = 1'b0;
        ram_clr   = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_widx;
        ram_wdata = r_word;
        ram_raddr = WW'(r_f >> 6);

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op   = i_op;
                    n_addr = i_addr;
                    n_len  = i_length;
                    n_n    = '0;
                    n_fr   = '0;
                    n_stat = ST_OK;
                    case (t_op'(i_op))
                        OP_INIT: begin
                            ram_clr  = 1'b1;
                            n_usable = '0;
                            n_state  = S_DONE;
                        end
                        OP_ADD: begin
                            n_state = S_A_FIRST;
                        end
                        OP_ALLOC: begin
                            n_w     = '0;
                            n_pend  = 1'b0;
                            n_stat  = ST_OOM;
                            n_state = S_L_SCAN;
                        end
                        OP_FREE_ADDR: begin
                            n_state = S_F_SHIFT;
                        end
                        OP_FREE_FRAME: begin
                            n_lo    = XW'(i_frame_in);
                            n_state = S_F_CHK;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            // ---- add region setup, one use of the shared unit per step, then the range check ----
            S_A_FIRST: begin
                su_round = 1'b1;
                n_lo     = XW'(su_q);
                n_state  = S_A_STOP;
            end
            S_A_STOP: begin
                su_b    = r_len;
                n_hi    = XW'(su_q);
                n_state = S_A_KLO;
            end
            S_A_KLO: begin
                su_a     = r_kstart;
                su_round = 1'b1;
                n_klo    = XW'(su_q);
                n_state  = S_A_KHI;
            end
            S_A_KHI: begin
                su_a     = r_kend;
                su_round = 1'b1;
                n_khi    = XW'(su_q);
                n_state  = S_A_RANGE;
            end
            S_A_RANGE: begin
                if (r_lo >= stop_c) begin
                    n_state = S_DONE;
                end else begin
                    n_f     = CW'(r_lo);
                    n_hi    = stop_c;
                    n_state = S_A_RD;
                end
            end
            S_A_RD: begin
                ram_raddr = WW'(r_f >> 6);
                n_widx    = WW'(r_f >> 6);
                n_state   = S_A_LD;
            end
            S_A_LD: begin
                n_word  = ram_rdata;
                n_state = S_A_BIT;
            end
            S_A_BIT: begin
                if (!skip) begin
                    n_word = r_word & ~(64'h1 << r_f[BIT_W-1:0]);
                    if (r_n != COUNT_MAX) begin
                        n_n = r_n + COUNT_W'(1);
                    end
                end
                n_f = f_next;
                if ((r_f[BIT_W-1:0] == {BIT_W{1'b1}}) || (XW'(f_next) >= r_hi)) begin
                    n_state = S_A_WR;
                end
            end
            S_A_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_widx;
                ram_wdata = r_word;
                n_state   = (f_x >= r_hi) ? S_DONE : S_A_RD;
            end

            // ---- allocate: pipelined word scan, then bit search ----
            S_L_SCAN: begin
                if (r_pend && (ram_rdata != '1)) begin
                    n_word  = ram_rdata;
                    n_sh    = ram_rdata;
                    n_widx  = r_pidx;
                    n_bit   = '0;
                    n_k     = '0;
                    n_state = S_L_BIT;
                end else if (r_pend && (r_pidx == LAST_W)) begin
                    n_state = S_DONE;
                end else begin
                    ram_raddr = r_w;
                    n_pend    = 1'b1;
                    n_pidx    = r_w;
                    n_w       = r_w + WW'(1);
                end
            end
            S_L_BIT: begin
                // lowest zero lies in the low 2h bits of r_sh
                if (low_ones) begin
                    n_sh  = r_sh >> h;
                    n_bit = r_bit + h[BIT_W-1:0];
                end
                n_k = r_k + 3'd1;
                if (r_k == 3'd5) begin
                    n_state = S_L_SET;
                end
            end
            S_L_SET: begin
                ram_we    = 1'b1;
                ram_waddr = r_widx;
                ram_wdata = r_word | (64'h1 << r_bit);
                n_fr      = FRAME_OUT_W'({r_widx, r_bit});
                n_stat    = ST_OK;
                n_state   = S_DONE;
            end

            // ---- free one frame ----
            S_F_SHIFT: begin
                n_lo    = XW'(su_q);
                n_state = S_F_CHK;
            end
            S_F_CHK: begin
                if (r_lo >= FC_X) begin
                    n_stat  = ST_RANGE;
                    n_state = S_DONE;
                end else begin
                    ram_raddr = WW'(r_lo >> 6);
                    n_f       = CW'(r_lo);
                    n_state   = S_F_MOD;
                end
            end
            S_F_MOD: begin
                ram_we    = 1'b1;
                ram_waddr = WW'(r_f >> 6);
                ram_wdata = ram_rdata & ~(64'h1 << r_f[BIT_W-1:0]);
                n_state   = S_DONE;
            end

            S_DONE: begin
                n_ovalid  = 1'b1;
                n_oframe  = r_fr;
                n_ostatus = r_stat;
                n_ofreed  = r_n;
                n_ototal  = r_usable;
                if (r_op == OP_ADD) begin
                    n_usable = (tot_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX
                                                             : tot_sum[COUNT_W-1:0];
                    n_ototal = n_usable;
                end
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_usable <= '0;
            r_pend   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_usable <= n_usable;
            r_pend   <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_addr    <= n_addr;
        r_len     <= n_len;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_klo     <= n_klo;
        r_khi     <= n_khi;
        r_f       <= n_f;
        r_widx    <= n_widx;
        r_word    <= n_word;
        r_sh      <= n_sh;
        r_bit     <= n_bit;
        r_k       <= n_k;
        r_w       <= n_w;
        r_pidx    <= n_pidx;
        r_n       <= n_n;
        r_stat    <= n_stat;
        r_fr      <= n_fr;
        r_oframe  <= n_oframe;
        r_ostatus <= n_ostatus;
        r_ofreed  <= n_ofreed;
        r_ototal  <= n_ototal;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_ovalid;
    assign o_frame        = r_oframe;
    assign o_status       = r_ostatus;
    assign o_pages_freed  = r_ofreed;
    assign o_usable_total = r_ototal;

`ifndef SYNTHESIS
    // every command passes through idle and done, so result beats never abut
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |=> !r_ovalid)
        else $error("result beat held for more than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_oom_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_ostatus == ST_OOM)) |-> (r_oframe == '0))
        else $error("out of memory result carries a frame number");

    a_usable_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_usable <= COUNT_MAX)
        else $error("usable page count above its ceiling");
`endif

endmodule
